FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the sparse pattern merge block.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SLPM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slpm assertion failed");

// Next-cycle implication, disabled in reset.
`define SLPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slpm assertion failed");

`endif

FILE: sv/slpm_pkg.sv
// Package of the sparse pattern merge block: sizes, widths and codes.
// Used by the interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package slpm_pkg;
    localparam int MAX_DIM     = 1024;
    localparam int MAX_ENTRIES = 16384;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 15;
    localparam int ENT_AW      = $clog2(MAX_ENTRIES);
    localparam int ACT_W       = 2;
    localparam int KIND_W      = 2;

    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_action ACT_LOAD_L = 2'd0;
    localparam t_action ACT_LOAD_U = 2'd1;
    localparam t_action ACT_BUILD  = 2'd2;
    localparam t_action ACT_READ   = 2'd3;

    localparam t_kind KIND_REPORT = 2'd0;
    localparam t_kind KIND_RP     = 2'd1;
    localparam t_kind KIND_COL    = 2'd2;
endpackage

FILE: sv/slpm_if.sv
// Valid/ready channel interfaces: command in, word out, size register write.
// Depends on slpm_pkg.
`timescale 1ns / 1ps

interface slpm_in_if;
    logic                      valid;
    logic                      ready;
    slpm_pkg::t_action         action;
    logic [slpm_pkg::IDX_W-1:0] row_index;
    logic [slpm_pkg::IDX_W-1:0] col_index;
    modport source(output valid, action, row_index, col_index, input ready);
    modport sink(input valid, action, row_index, col_index, output ready);
endinterface

interface slpm_out_if;
    logic                       valid;
    logic                       ready;
    slpm_pkg::t_kind            word_kind;
    logic [slpm_pkg::CNT_W-1:0] word_value;
    logic                       last_word;
    logic                       error_flag;
    modport source(output valid, word_kind, word_value, last_word, error_flag, input ready);
    modport sink(input valid, word_kind, word_value, last_word, error_flag, output ready);
endinterface

interface slpm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [slpm_pkg::DIM_W-1:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

FILE: sv/slpm_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
// Generic; no package dependency.
`timescale 1ns / 1ps

module slpm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

FILE: sv/sparse_lu_pattern_merge_csc_to_csr.sv
// Merges L and U coordinate patterns into one CSR pattern by counting sort.
// Depends on slpm_pkg, slpm_if, slpm_ram and assert_macros.svh.
//
// Loads are written in the cycle they are accepted. A read word passes a memory
// read, then the output register. A build is accepted, then runs a sequencer
// over four RAMs: a clearing pass over the n+1 row pointers, a count pass that
// reads each stored entry, reads its row pointer and writes it back (an entry
// left out skips the pointer read and write) and then closes, a prefix sum
// that reads and rewrites each row pointer, a scatter pass that reads each
// stored entry, reads its fill offset and writes column and offset (an entry
// left out skips both) and then closes, then the report once the output
// register is free. No clearing pass follows reset. Commands are taken only
// while the sequencer is idle; a finished word waits in the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sparse_lu_pattern_merge_csc_to_csr (
    input  logic   i_clk,
    input  logic   i_rst_n,
    slpm_in_if.sink    i_in_ch,
    slpm_out_if.source o_out_ch,
    slpm_cfg_if.sink   i_cfg_ch
);
    localparam int DIM_W  = slpm_pkg::DIM_W;
    localparam int IDX_W  = slpm_pkg::IDX_W;
    localparam int CNT_W  = slpm_pkg::CNT_W;
    localparam int ENT_AW = slpm_pkg::ENT_AW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CLR  = 4'd2;
    localparam logic [3:0] S_CA   = 4'd3;
    localparam logic [3:0] S_CB   = 4'd4;
    localparam logic [3:0] S_CC   = 4'd5;
    localparam logic [3:0] S_PA   = 4'd6;
    localparam logic [3:0] S_PB   = 4'd7;
    localparam logic [3:0] S_SA   = 4'd8;
    localparam logic [3:0] S_SB   = 4'd9;
    localparam logic [3:0] S_SC   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    // control registers
    logic [3:0]       r_state, n_state;
    logic [DIM_W-1:0] r_size, n_size;
    logic [DIM_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_k, n_k;
    logic [DIM_W-1:0] r_a, n_a;
    logic [CNT_W-1:0] r_entry_count, n_entry_count;
    logic [CNT_W-1:0] r_rd_ptr, n_rd_ptr;
    logic             r_ovf, n_ovf;
    logic [DIM_W-1:0] r_bsize, n_bsize;
    logic [CNT_W-1:0] r_btotal, n_btotal;
    logic             r_built, n_built;
    logic             r_ovalid, n_ovalid;
    // payload registers
    logic [CNT_W-1:0]    r_sum, n_sum;
    logic [IDX_W-1:0]    r_row, n_row;
    logic [IDX_W-1:0]    r_col, n_col;
    slpm_pkg::t_kind     r_rd_kind, n_rd_kind;
    logic                r_rd_last, n_rd_last;
    slpm_pkg::t_kind     r_okind, n_okind;
    logic [CNT_W-1:0]    r_ovalue, n_ovalue;
    logic                r_olast, n_olast;
    logic                r_oerr, n_oerr;

    // memory ports
    logic                ent_we, ent_re;
    logic [ENT_AW-1:0]   ent_waddr, ent_raddr;
    logic [2*IDX_W-1:0]  ent_wdata, ent_q;
    logic                rp_we, rp_re;
    logic [DIM_W-1:0]    rp_waddr, rp_raddr;
    logic [CNT_W-1:0]    rp_wdata, rp_q;
    logic                fill_we, fill_re;
    logic [IDX_W-1:0]    fill_waddr, fill_raddr;
    logic [CNT_W-1:0]    fill_wdata, fill_q;
    logic                col_we, col_re;
    logic [ENT_AW-1:0]   col_waddr, col_raddr;
    logic [IDX_W-1:0]    col_wdata, col_q;

    logic             in_acc;
    logic             load_acc;
    logic             out_free;
    logic [DIM_W-1:0] eff_size;
    logic [CNT_W-1:0] rd_k;
    logic [CNT_W-1:0] sum_next;
    logic [IDX_W-1:0] q_row, q_col;
    logic             q_bad;

    slpm_ram #(.DEPTH(slpm_pkg::MAX_ENTRIES), .WIDTH(2*IDX_W)) u_entry_ram (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_re(ent_re), .i_raddr(ent_raddr), .o_rdata(ent_q)
    );
    slpm_ram #(.DEPTH(slpm_pkg::MAX_DIM + 1), .WIDTH(CNT_W)) u_rp_ram (
        .i_clk(i_clk), .i_we(rp_we), .i_waddr(rp_waddr), .i_wdata(rp_wdata),
        .i_re(rp_re), .i_raddr(rp_raddr), .o_rdata(rp_q)
    );
    slpm_ram #(.DEPTH(slpm_pkg::MAX_DIM), .WIDTH(CNT_W)) u_fill_ram (
        .i_clk(i_clk), .i_we(fill_we), .i_waddr(fill_waddr), .i_wdata(fill_wdata),
        .i_re(fill_re), .i_raddr(fill_raddr), .o_rdata(fill_q)
    );
    slpm_ram #(.DEPTH(slpm_pkg::MAX_ENTRIES), .WIDTH(IDX_W)) u_col_ram (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(col_waddr), .i_wdata(col_wdata),
        .i_re(col_re), .i_raddr(col_raddr), .o_rdata(col_q)
    );

    assign i_in_ch.ready       = (r_state == S_IDLE);
    assign i_cfg_ch.ready      = 1'b1;
    assign in_acc              = i_in_ch.valid && i_in_ch.ready;
    assign load_acc            = in_acc && ((i_in_ch.action == slpm_pkg::ACT_LOAD_L) ||
                                            (i_in_ch.action == slpm_pkg::ACT_LOAD_U));
    assign out_free            = !r_ovalid || o_out_ch.ready;
    assign o_out_ch.valid      = r_ovalid;
    assign o_out_ch.word_kind  = r_okind;
    assign o_out_ch.word_value = r_ovalue;
    assign o_out_ch.last_word  = r_olast;
    assign o_out_ch.error_flag = r_oerr;

    always_comb begin
        if (r_size == '0) begin
            eff_size = DIM_W'(1);
        end else if (r_size > DIM_W'(slpm_pkg::MAX_DIM)) begin
            eff_size = DIM_W'(slpm_pkg::MAX_DIM);
        end else begin
            eff_size = r_size;
        end
    end

    assign rd_k     = r_rd_ptr - CNT_W'(r_bsize) - CNT_W'(1);
    assign sum_next = r_sum + rp_q;
    assign q_row    = ent_q[2*IDX_W-1:IDX_W];
    assign q_col    = ent_q[IDX_W-1:0];
    assign q_bad    = ({1'b0, q_row} >= r_n) || ({1'b0, q_col} >= r_n);

    always_comb begin
        n_state       = r_state;
        n_size        = r_size;
        n_n           = r_n;
        n_k           = r_k;
        n_a           = r_a;
        n_entry_count = r_entry_count;
        n_rd_ptr      = r_rd_ptr;
        n_ovf         = r_ovf;
        n_bsize       = r_bsize;
        n_btotal      = r_btotal;
        n_built       = r_built;
        n_ovalid      = r_ovalid;
        n_sum         = r_sum;
        n_row         = r_row;
        n_col         = r_col;
        n_rd_kind     = r_rd_kind;
        n_rd_last     = r_rd_last;
        n_okind       = r_okind;
        n_ovalue      = r_ovalue;
        n_olast       = r_olast;
        n_oerr        = r_oerr;

        ent_we     = 1'b0;
        ent_waddr  = r_entry_count[ENT_AW-1:0];
        ent_wdata  = {i_in_ch.row_index, i_in_ch.col_index};
        ent_re     = 1'b0;
        ent_raddr  = r_k[ENT_AW-1:0];
        rp_we      = 1'b0;
        rp_waddr   = r_a;
        rp_wdata   = '0;
        rp_re      = 1'b0;
        rp_raddr   = r_a;
        fill_we    = 1'b0;
        fill_waddr = r_row;
        fill_wdata = '0;
        fill_re    = 1'b0;
        fill_raddr = q_row;
        col_we     = 1'b0;
        col_waddr  = fill_q[ENT_AW-1:0];
        col_wdata  = r_col;
        col_re     = 1'b0;
        col_raddr  = rd_k[ENT_AW-1:0];

        if (i_cfg_ch.valid) begin
            n_size = i_cfg_ch.data;
        end
        if (r_ovalid && o_out_ch.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_ch.action) inside
                        slpm_pkg::ACT_LOAD_L, slpm_pkg::ACT_LOAD_U: begin
                            if (({1'b0, i_in_ch.row_index} >= eff_size) ||
                                ({1'b0, i_in_ch.col_index} >= eff_size)) begin
                                n_ovf = 1'b1;
                            end else if (i_in_ch.action == slpm_pkg::ACT_LOAD_L &&
                                         i_in_ch.row_index == i_in_ch.col_index) begin
                                // skip the diagonal of L
                            end else if (r_entry_count >=
                                         CNT_W'(slpm_pkg::MAX_ENTRIES)) begin
                                n_ovf = 1'b1;
                            end else begin
                                ent_we        = 1'b1;
                                n_entry_count = r_entry_count + CNT_W'(1);
                            end
                        end
                        slpm_pkg::ACT_BUILD: begin
                            n_n     = eff_size;
                            n_a     = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                            if (r_rd_ptr <= CNT_W'(r_bsize)) begin
                                rp_re     = 1'b1;
                                rp_raddr  = r_rd_ptr[DIM_W-1:0];
                                n_rd_kind = slpm_pkg::KIND_RP;
                                n_rd_last = 1'b0;
                                n_state   = S_RD;
                            end else if (rd_k < r_btotal) begin
                                col_re    = 1'b1;
                                n_rd_kind = slpm_pkg::KIND_COL;
                                n_rd_last = (rd_k + CNT_W'(1) == r_btotal);
                                n_state   = S_RD;
                            end
                            // past the end: drop the command
                        end
                    endcase
                end
            end
            S_RD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = r_rd_kind;
                    n_olast  = r_rd_last;
                    n_oerr   = r_ovf;
                    if (r_rd_kind == slpm_pkg::KIND_COL) begin
                        n_ovalue = CNT_W'(col_q);
                    end else begin
                        // before the first build the pointer RAM holds nothing
                        n_ovalue = r_built ? rp_q : '0;
                    end
                    n_rd_ptr = r_rd_ptr + CNT_W'(1);
                    n_state  = S_IDLE;
                end
            end
            S_CLR: begin
                rp_we = 1'b1;
                if (r_a == r_n) begin
                    n_k     = '0;
                    n_state = S_CA;
                end else begin
                    n_a = r_a + DIM_W'(1);
                end
            end
            S_CA: begin
                if (r_k == r_entry_count) begin
                    n_a     = DIM_W'(1);
                    n_sum   = '0;
                    n_state = S_PA;
                end else begin
                    ent_re  = 1'b1;
                    n_state = S_CB;
                end
            end
            S_CB: begin
                n_row = q_row;
                n_col = q_col;
                if (q_bad) begin
                    n_ovf   = 1'b1;
                    n_k     = r_k + CNT_W'(1);
                    n_state = S_CA;
                end else begin
                    rp_re    = 1'b1;
                    rp_raddr = {1'b0, q_row} + DIM_W'(1);
                    n_state  = S_CC;
                end
            end
            S_CC: begin
                rp_we    = 1'b1;
                rp_waddr = {1'b0, r_row} + DIM_W'(1);
                rp_wdata = rp_q + CNT_W'(1);
                n_k      = r_k + CNT_W'(1);
                n_state  = S_CA;
            end
            S_PA: begin
                rp_re   = 1'b1;
                n_state = S_PB;
            end
            S_PB: begin
                // rp[a] becomes the running sum; fill[a-1] starts at rp[a-1]
                rp_we      = 1'b1;
                rp_wdata   = sum_next;
                fill_we    = 1'b1;
                fill_waddr = IDX_W'(r_a - DIM_W'(1));
                fill_wdata = r_sum;
                n_sum      = sum_next;
                if (r_a == r_n) begin
                    n_k     = '0;
                    n_state = S_SA;
                end else begin
                    n_a     = r_a + DIM_W'(1);
                    n_state = S_PA;
                end
            end
            S_SA: begin
                if (r_k == r_entry_count) begin
                    n_bsize  = r_n;
                    n_btotal = r_sum;
                    n_rd_ptr = '0;
                    n_built  = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    ent_re  = 1'b1;
                    n_state = S_SB;
                end
            end
            S_SB: begin
                n_row = q_row;
                n_col = q_col;
                if (q_bad) begin
                    n_k     = r_k + CNT_W'(1);
                    n_state = S_SA;
                end else begin
                    fill_re = 1'b1;
                    n_state = S_SC;
                end
            end
            S_SC: begin
                col_we     = 1'b1;
                fill_we    = 1'b1;
                fill_wdata = fill_q + CNT_W'(1);
                n_k        = r_k + CNT_W'(1);
                n_state    = S_SA;
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = slpm_pkg::KIND_REPORT;
                    n_ovalue = r_entry_count;
                    n_olast  = 1'b0;
                    n_oerr   = r_ovf;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_size        <= DIM_W'(slpm_pkg::MAX_DIM);
            r_n           <= DIM_W'(1);
            r_k           <= '0;
            r_a           <= '0;
            r_entry_count <= '0;
            r_rd_ptr      <= '0;
            r_ovf         <= 1'b0;
            r_bsize       <= DIM_W'(1);
            r_btotal      <= '0;
            r_built       <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_size        <= n_size;
            r_n           <= n_n;
            r_k           <= n_k;
            r_a           <= n_a;
            r_entry_count <= n_entry_count;
            r_rd_ptr      <= n_rd_ptr;
            r_ovf         <= n_ovf;
            r_bsize       <= n_bsize;
            r_btotal      <= n_btotal;
            r_built       <= n_built;
            r_ovalid      <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_row     <= n_row;
        r_col     <= n_col;
        r_rd_kind <= n_rd_kind;
        r_rd_last <= n_rd_last;
        r_okind   <= n_okind;
        r_ovalue  <= n_ovalue;
        r_olast   <= n_olast;
        r_oerr    <= n_oerr;
    end

    `SLPM_ASSERT_IMPL(a_count_bound, 1'b1, r_entry_count <= CNT_W'(slpm_pkg::MAX_ENTRIES))
    `SLPM_ASSERT_NEXT(a_full_holds, load_acc && r_entry_count == CNT_W'(slpm_pkg::MAX_ENTRIES), $stable(r_entry_count))
    `SLPM_ASSERT_IMPL(a_col_after_build, r_ovalid && r_okind == slpm_pkg::KIND_COL, r_built)
    `SLPM_ASSERT_NEXT(a_report_rewinds, r_state == S_DONE && out_free, r_rd_ptr == '0 && r_ovalid)
endmodule

FILE: bench/sparse_lu_pattern_merge_csc_to_csr_tb.sv
// Testbench of the sparse pattern merge block: directed and random bursts of load,
// build and read commands checked word by word against an in-bench prediction.
// Depends on slpm_pkg, slpm_if and the top level sparse_lu_pattern_merge_csc_to_csr.
`timescale 1ns / 1ps

module sparse_lu_pattern_merge_csc_to_csr_tb;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        slpm_pkg::t_action             action;
        logic [slpm_pkg::IDX_W-1:0]    row_index;
        logic [slpm_pkg::IDX_W-1:0]    col_index;
    } t_cmd;

    typedef struct {
        slpm_pkg::t_kind               kind;
        logic [slpm_pkg::CNT_W-1:0]    value;
        logic                          last;
        logic                          err;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    slpm_in_if  in_ch();
    slpm_out_if out_ch();
    slpm_cfg_if cfg_ch();

    sparse_lu_pattern_merge_csc_to_csr dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch.sink),
        .o_out_ch (out_ch.source),
        .i_cfg_ch (cfg_ch.sink)
    );

    always #10 i_clk = ~i_clk;

    // Predicted block state
    int    size_reg;
    int    ent_row[$];
    int    ent_col[$];
    int    row_ptr[0:slpm_pkg::MAX_DIM];
    int    row_fill[0:slpm_pkg::MAX_DIM-1];
    int    col_out[0:slpm_pkg::MAX_ENTRIES-1];
    int    rd_pos;
    bit    overflow;
    int    built_n;
    int    built_total;

    t_cmd  pending_cmds[$];
    t_word expected_words[$];
    int    failures;
    int    words_checked;
    int    cmds_sent;
    int    builds_sent;
    longint cycles;
    bit    long_hold_go;

    function automatic int active_size();
        if (size_reg == 0) return 1;
        if (size_reg > slpm_pkg::MAX_DIM) return slpm_pkg::MAX_DIM;
        return size_reg;
    endfunction

    function automatic void push_word(slpm_pkg::t_kind kind, int value, bit last);
        t_word w;
        w.kind  = kind;
        w.value = value[slpm_pkg::CNT_W-1:0];
        w.last  = last;
        w.err   = overflow;
        expected_words.push_back(w);
    endfunction

    function automatic void build_pattern();
        int n;
        int pos;
        n = active_size();
        for (int r = 0; r <= slpm_pkg::MAX_DIM; r++) row_ptr[r] = 0;
        for (int r = 0; r < slpm_pkg::MAX_DIM; r++) row_fill[r] = 0;
        for (int k = 0; k < ent_row.size(); k++) begin
            if (ent_row[k] >= n || ent_col[k] >= n) overflow = 1'b1;
            else row_ptr[ent_row[k] + 1]++;
        end
        for (int r = 1; r <= n; r++) row_ptr[r] += row_ptr[r-1];
        for (int k = 0; k < ent_row.size(); k++) begin
            if (ent_row[k] < n && ent_col[k] < n) begin
                pos = row_ptr[ent_row[k]] + row_fill[ent_row[k]];
                if (pos < slpm_pkg::MAX_ENTRIES) col_out[pos] = ent_col[k];
                row_fill[ent_row[k]]++;
            end
        end
        built_n     = n;
        built_total = row_ptr[n];
        rd_pos      = 0;
    endfunction

    function automatic void merge_step(t_cmd c);
        int n;
        int k;
        n = active_size();
        case (c.action)
            slpm_pkg::ACT_LOAD_L, slpm_pkg::ACT_LOAD_U: begin
                if (c.row_index >= n || c.col_index >= n) overflow = 1'b1;
                else if (c.action == slpm_pkg::ACT_LOAD_L && c.row_index == c.col_index) ;
                else if (ent_row.size() >= slpm_pkg::MAX_ENTRIES) overflow = 1'b1;
                else begin
                    ent_row.push_back(c.row_index);
                    ent_col.push_back(c.col_index);
                end
            end
            slpm_pkg::ACT_BUILD: begin
                build_pattern();
                push_word(slpm_pkg::KIND_REPORT, ent_row.size(), 1'b0);
            end
            default: begin
                if (rd_pos <= built_n) begin
                    push_word(slpm_pkg::KIND_RP, row_ptr[rd_pos], 1'b0);
                    rd_pos++;
                end else begin
                    k = rd_pos - (built_n + 1);
                    if (k < built_total && k < slpm_pkg::MAX_ENTRIES) begin
                        push_word(slpm_pkg::KIND_COL, col_out[k], k + 1 == built_total);
                        rd_pos++;
                    end
                end
            end
        endcase
    endfunction

    // Command driver: bursts of random length with random gaps
    t_cmd cur_cmd;
    int   burst_left;
    int   gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.action    <= slpm_pkg::ACT_LOAD_L;
            in_ch.row_index <= '0;
            in_ch.col_index <= '0;
            burst_left      <= 1;
            gap_left        <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the word until taken
        end else begin
            if (in_ch.valid) begin
                merge_step(cur_cmd);
                cmds_sent++;
                if (cur_cmd.action == slpm_pkg::ACT_BUILD) builds_sent++;
            end
            if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cur_cmd          = pending_cmds.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.action    <= cur_cmd.action;
                in_ch.row_index <= cur_cmd.row_index;
                in_ch.col_index <= cur_cmd.col_index;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Word monitor with its own stall pattern and one long hold-off
    int  stall_mode;
    int  mode_left;
    int  hold_left;
    bit  hold_seen;
    bit  go_r;

    always @(posedge i_clk) begin
        t_word e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_mode   <= 0;
            mode_left    <= 0;
            hold_left    <= 0;
            go_r         <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word kind=%0d value=%0d", out_ch.word_kind,
                           out_ch.word_value);
                    failures++;
                end else begin
                    e = expected_words.pop_front();
                    words_checked++;
                    if (out_ch.word_kind !== e.kind) begin
                        $error("word_kind: expected %0d, got %0d", e.kind, out_ch.word_kind);
                        failures++;
                    end
                    if (out_ch.word_value !== e.value) begin
                        $error("word_value: expected %0d, got %0d", e.value,
                               out_ch.word_value);
                        failures++;
                    end
                    if (out_ch.last_word !== e.last) begin
                        $error("last_word: expected %0d, got %0d", e.last, out_ch.last_word);
                        failures++;
                    end
                    if (out_ch.error_flag !== e.err) begin
                        $error("error_flag: expected %0d, got %0d", e.err, out_ch.error_flag);
                        failures++;
                    end
                end
            end
            go_r <= long_hold_go;
            if (long_hold_go && !go_r) begin
                hold_left    <= 400;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode <= $urandom_range(0, 2);
                    mode_left  <= $urandom_range(8, 120);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (stall_mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= $urandom_range(0, 1);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_cmd(slpm_pkg::t_action a, int r, int c);
        t_cmd x;
        x.action    = a;
        x.row_index = r[slpm_pkg::IDX_W-1:0];
        x.col_index = c[slpm_pkg::IDX_W-1:0];
        pending_cmds.push_back(x);
    endtask

    // Hold until every command is taken and every word has come back
    task automatic drain();
        while (pending_cmds.size() > 0 || in_ch.valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_size(int v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v[slpm_pkg::DIM_W-1:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        size_reg = v;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic queue_reads(int cnt);
        for (int i = 0; i < cnt; i++) queue_cmd(slpm_pkg::ACT_READ, $urandom, $urandom);
    endtask

    task automatic random_loads(int cnt);
        int n;
        int c;
        n = active_size();
        c = 0;
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_cmd(slpm_pkg::t_action'($urandom_range(0, 1)),
                          $urandom_range(0, 1023), $urandom_range(0, 1023));
            end else begin
                if (c < n - 1 && $urandom_range(0, 2) == 0) c = c + $urandom_range(1, 2);
                if (c > n - 1) c = n - 1;
                queue_cmd(slpm_pkg::t_action'($urandom_range(0, 1)),
                          $urandom_range(0, n - 1), c);
            end
        end
    endtask

    initial begin
        int sizes[4];
        int n_sel;
        int stream_len;
        size_reg       = slpm_pkg::MAX_DIM;
        rd_pos         = 0;
        overflow       = 1'b0;
        built_n        = 1;
        built_total    = 0;
        failures       = 0;
        words_checked  = 0;
        cmds_sent      = 0;
        builds_sent    = 0;
        cycles         = 0;
        long_hold_go   = 1'b0;
        hold_seen      = 1'b0;
        for (int r = 0; r <= slpm_pkg::MAX_DIM; r++) row_ptr[r] = 0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reads before any build, corner loads, diagonal skip
        queue_reads(3);
        queue_cmd(slpm_pkg::ACT_LOAD_L, 5, 5);
        queue_cmd(slpm_pkg::ACT_LOAD_U, 0, 0);
        queue_cmd(slpm_pkg::ACT_LOAD_L, 1023, 0);
        queue_cmd(slpm_pkg::ACT_LOAD_L, 682, 341);
        queue_cmd(slpm_pkg::ACT_LOAD_U, 341, 682);
        queue_cmd(slpm_pkg::ACT_LOAD_U, 0, 1023);
        queue_cmd(slpm_pkg::ACT_LOAD_U, 1023, 1023);
        queue_cmd(slpm_pkg::ACT_BUILD, 0, 0);
        drain();
        queue_reads(8);
        drain();

        // Shrink: out-of-range load, stored entries beyond n left out
        write_size(3);
        queue_cmd(slpm_pkg::ACT_LOAD_U, 5, 1);
        queue_cmd(slpm_pkg::ACT_LOAD_U, 2, 1);
        queue_cmd(slpm_pkg::ACT_LOAD_L, 1, 2);
        queue_cmd(slpm_pkg::ACT_BUILD, 0, 0);
        drain();
        queue_reads(4 + built_total + 2);
        drain();

        write_size(0);
        queue_cmd(slpm_pkg::ACT_BUILD, 0, 0);
        queue_reads(3);
        drain();

        // Random phases of load, build and read with varied sizes
        sizes = '{1, 2, 1024, 2047};
        for (int ph = 0; cmds_sent < 900; ph++) begin
            n_sel = $urandom_range(0, 9);
            if (n_sel < 4 && (n_sel < 2 || $urandom_range(0, 5) == 0))
                write_size(sizes[n_sel]);
            else
                write_size($urandom_range(3, 24));
            random_loads($urandom_range(0, 40));
            if ($urandom_range(0, 5) != 0) begin
                queue_cmd(slpm_pkg::ACT_BUILD, $urandom, $urandom);
                drain();
                stream_len = built_n + 1 + built_total;
                if (stream_len > 80) stream_len = $urandom_range(40, 80);
                else if ($urandom_range(0, 3) == 0)
                    stream_len = $urandom_range(0, stream_len);
                else
                    stream_len = stream_len + $urandom_range(0, 2);
                if (ph >= 3 && !hold_seen && stream_len > 4) begin
                    long_hold_go = 1'b1;
                    hold_seen    = 1'b1;
                end
                queue_reads(stream_len);
            end
            drain();
            long_hold_go = 1'b0;
        end

        write_size(slpm_pkg::MAX_DIM);
        queue_cmd(slpm_pkg::ACT_BUILD, 0, 0);
        queue_reads(5);
        drain();

        $display("Covered %0d commands with %0d builds; %0d words checked.", cmds_sent,
                 builds_sent, words_checked);
        $display("Sizes from 0 to 2047, reads past the end and sticky overflow included.");
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
